// ===== hdl/sms_pkg.sv =====
// Shared types and codes for the SPI master shift engine.
package sms_pkg;

    // Input command codes
    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_START   = 2'd1,
        CMD_SELECT  = 2'd2,
        CMD_RELEASE = 2'd3
    } sms_cmd_t;

    // Configuration register indexes (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_DIVIDER  = 2'd0,
        REG_POLARITY = 2'd1,
        REG_PHASE    = 2'd2,
        REG_LSB      = 2'd3
    } sms_reg_t;

    localparam int RX_DATA_BITS = 16;
    localparam int RES_BITS     = 24;
    localparam logic [15:0] DIVIDER_RESET = 16'd2;

    // One result transaction
    typedef struct packed {
        logic [RX_DATA_BITS-1:0] rx_data;
        logic                    done_res;
        logic                    busy_res;
        logic                    select_n;
        logic                    mosi;
        logic                    sclk;
    } sms_result_t;

endpackage

// ===== hdl/sms_out_buf.sv =====
// Output register with a skid stage for the result channel.
module sms_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  sms_pkg::sms_result_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sms_pkg::sms_result_t out_data
);
    import sms_pkg::*;

    logic        main_valid_reg;
    logic        skid_valid_reg;
    sms_result_t main_data_reg;
    sms_result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !main_valid_reg) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= in_valid;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge aclk) begin
        if (out_ready || !main_valid_reg) begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_valid && !skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

    // Skid entry only exists behind a held main entry
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry without main entry");

    // Skid fills whenever a transaction arrives while the main entry is stalled
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready && main_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("stalled transaction not captured in skid");

endmodule

// ===== hdl/spi_master_shift_engine_core.sv =====
// Top level of the SPI master shift engine: config port, shift state, result path.
//
//   channel   ports            contents
//   input     s_t*             one tick: cmd in tuser, tx_data/wide/miso in tdata
//   result    m_t*             pin levels, busy, done and received word per tick
//   config    APB p*           divider, CPOL, CPHA, bit order at 0x0/0x4/0x8/0xC
//
// One transaction is accepted per cycle while s_tready is high; its result is registered in the output buffer.
// The whole tick update is one combinational pass from the shift state to the
// result register; the skid stage keeps s_tready registered.
// Reset (aresetn low, synchronous) idles the engine: select released, SCLK low.
// A stalled result channel holds at most two results before s_tready drops.
module spi_master_shift_engine_core #(
    parameter int MAX_WORD_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] tx_data, [16] wide, [17] miso, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] sclk, [1] mosi, [2] select_n, [3] busy_res,
                                   // [4] done_res, [20:5] rx_data, rest zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sms_pkg::*;

    localparam int W   = MAX_WORD_BITS;
    localparam int BLW = $clog2(W + 1);

    // Configuration registers
    logic [15:0] div_reg;
    logic        cpol_reg;
    logic        cpha_reg;
    logic        lsb_reg;

    // Shift engine state
    logic [W-1:0]   tx_shift_reg,     tx_shift_next;
    logic [W-1:0]   rx_shift_reg,     rx_shift_next;
    logic [BLW-1:0] bits_left_reg,    bits_left_next;
    logic [15:0]    tick_count_reg,   tick_count_next;
    logic           second_half_reg,  second_half_next;
    logic           sclk_level_reg,   sclk_level_next;
    logic           mosi_level_reg,   mosi_level_next;
    logic           select_level_reg, select_level_next;
    logic           wide_mode_reg,    wide_mode_next;

    logic        accept;
    logic        cfg_we;
    sms_reg_t    cfg_idx;
    sms_cmd_t    cmd;
    logic [15:0] tx_data_in;
    logic        wide_in;
    logic        miso_in;

    logic [14:0]    half;
    logic [15:0]    tick_inc;
    logic           half_done;
    logic           busy;
    logic           start_load;
    logic [W-1:0]   full_mask;
    logic [W-1:0]   narrow_mask;
    logic [W-1:0]   cur_mask;
    logic [31:0]    data32;
    logic [W-1:0]   load_word;
    logic [W-1:0]   drv_src;
    logic           drv_wide;
    logic [W-1:0]   drv_mask;
    logic           drv_mosi;
    logic [W-1:0]   drv_tx;
    logic [W-1:0]   smp_tmp;
    logic [W-1:0]   smp_rx;
    logic [31:0]    rx32;
    logic           done;
    logic [15:0]    rx_out;
    logic           buf_ready;
    sms_result_t    res_next;
    sms_result_t    res_out;

    // Field unpacking
    assign cmd        = sms_cmd_t'(s_tuser);
    assign tx_data_in = s_tdata[15:0];
    assign wide_in    = s_tdata[16];
    assign miso_in    = s_tdata[17];
    assign accept     = s_tvalid && buf_ready;
    assign s_tready   = buf_ready;

    // APB register port
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = sms_reg_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_reg  <= DIVIDER_RESET;
            cpol_reg <= 1'b0;
            cpha_reg <= 1'b0;
            lsb_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_DIVIDER:  div_reg  <= pwdata[15:0];
                REG_POLARITY: cpol_reg <= pwdata[0];
                REG_PHASE:    cpha_reg <= pwdata[0];
                REG_LSB:      lsb_reg  <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            REG_DIVIDER:  prdata = {16'd0, div_reg};
            REG_POLARITY: prdata = {31'd0, cpol_reg};
            REG_PHASE:    prdata = {31'd0, cpha_reg};
            REG_LSB:      prdata = {31'd0, lsb_reg};
            default:      prdata = '0;
        endcase
    end

    // Half period timing
    assign half      = (div_reg[15:1] == 15'd0) ? 15'd1 : div_reg[15:1];
    assign tick_inc  = tick_count_reg + 16'd1;
    assign half_done = tick_inc >= {1'b0, half};
    assign busy      = bits_left_reg != '0;
    assign start_load = !busy && (cmd == CMD_START);

    // Word masks and load word
    assign full_mask   = '1;
    assign narrow_mask = W'(8'hFF);
    assign cur_mask    = wide_mode_reg ? full_mask : narrow_mask;
    assign data32      = {16'd0, tx_data_in};
    assign load_word   = data32[W-1:0] & (wide_in ? full_mask : narrow_mask);

    // Transmit bit drive, shared by start and edge ticks
    assign drv_src  = start_load ? load_word : tx_shift_reg;
    assign drv_wide = start_load ? wide_in : wide_mode_reg;
    assign drv_mask = drv_wide ? full_mask : narrow_mask;
    assign drv_mosi = lsb_reg ? drv_src[0] : (drv_wide ? drv_src[W-1] : drv_src[7]);
    assign drv_tx   = lsb_reg ? (drv_src >> 1) : ((drv_src << 1) & drv_mask);

    // Receive bit sample
    always_comb begin
        smp_tmp = rx_shift_reg >> 1;
        if (wide_mode_reg) begin
            smp_tmp[W-1] = miso_in;
        end else begin
            smp_tmp[7] = miso_in;
        end
        if (lsb_reg) begin
            smp_rx = smp_tmp & cur_mask;
        end else begin
            smp_rx = ((rx_shift_reg << 1) | W'(miso_in)) & cur_mask;
        end
    end

    // Tick update
    always_comb begin
        tx_shift_next     = tx_shift_reg;
        rx_shift_next     = rx_shift_reg;
        bits_left_next    = bits_left_reg;
        tick_count_next   = tick_count_reg;
        second_half_next  = second_half_reg;
        sclk_level_next   = sclk_level_reg;
        mosi_level_next   = mosi_level_reg;
        select_level_next = select_level_reg;
        wide_mode_next    = wide_mode_reg;
        done              = 1'b0;
        rx32              = '0;

        if (cmd == CMD_SELECT) begin
            select_level_next = 1'b0;
        end else if (cmd == CMD_RELEASE) begin
            select_level_next = 1'b1;
        end

        if (busy) begin
            tick_count_next = tick_inc;
            if (half_done) begin
                tick_count_next = '0;
                if (!second_half_reg) begin
                    // leading edge
                    second_half_next = 1'b1;
                    sclk_level_next  = !cpol_reg;
                    if (cpha_reg) begin
                        mosi_level_next = drv_mosi;
                        tx_shift_next   = drv_tx;
                    end else begin
                        rx_shift_next = smp_rx;
                    end
                end else begin
                    // trailing edge
                    second_half_next = 1'b0;
                    sclk_level_next  = cpol_reg;
                    if (cpha_reg) begin
                        rx_shift_next = smp_rx;
                    end
                    bits_left_next = bits_left_reg - BLW'(1);
                    if (bits_left_reg == BLW'(1)) begin
                        done = 1'b1;
                        rx32 = 32'(rx_shift_next & cur_mask);
                    end else if (!cpha_reg) begin
                        mosi_level_next = drv_mosi;
                        tx_shift_next   = drv_tx;
                    end
                end
            end
        end else if (start_load) begin
            wide_mode_next   = wide_in;
            rx_shift_next    = '0;
            bits_left_next   = wide_in ? BLW'(W) : BLW'(8);
            tick_count_next  = '0;
            second_half_next = 1'b0;
            sclk_level_next  = cpol_reg;
            if (!cpha_reg) begin
                mosi_level_next = drv_mosi;
                tx_shift_next   = drv_tx;
            end else begin
                tx_shift_next = load_word;
            end
        end else begin
            sclk_level_next = cpol_reg;
        end
    end

    assign rx_out = rx32[15:0];

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_shift_reg     <= '0;
            rx_shift_reg     <= '0;
            bits_left_reg    <= '0;
            tick_count_reg   <= '0;
            second_half_reg  <= 1'b0;
            sclk_level_reg   <= 1'b0;
            mosi_level_reg   <= 1'b0;
            select_level_reg <= 1'b1;
            wide_mode_reg    <= 1'b0;
        end else if (accept) begin
            tx_shift_reg     <= tx_shift_next;
            rx_shift_reg     <= rx_shift_next;
            bits_left_reg    <= bits_left_next;
            tick_count_reg   <= tick_count_next;
            second_half_reg  <= second_half_next;
            sclk_level_reg   <= sclk_level_next;
            mosi_level_reg   <= mosi_level_next;
            select_level_reg <= select_level_next;
            wide_mode_reg    <= wide_mode_next;
        end
    end

    // Result transaction
    always_comb begin
        res_next.rx_data  = rx_out;
        res_next.done_res = done;
        res_next.busy_res = bits_left_next != '0;
        res_next.select_n = select_level_next;
        res_next.mosi     = mosi_level_next;
        res_next.sclk     = sclk_level_next;
    end

    sms_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (buf_ready),
        .in_data   (res_next),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_out)
    );

    assign m_tdata = {3'd0, res_out};

    // Bit counter never exceeds the word length
    a_bits_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_left_reg <= BLW'(W))
        else $error("bit counter out of range");

    // Done only on the tick that completes the last bit
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && res_next.done_res) |-> (bits_left_reg == BLW'(1) && second_half_reg))
        else $error("done raised before last bit");

    // Without an edge the bit count holds
    a_no_edge_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && busy && !half_done) |=> (bits_left_reg == $past(bits_left_reg)))
        else $error("bit count moved without an SCLK edge");

endmodule
